FILE: rtl/karp_pkg.sv
// Shared constants, phase codes and types for the kernel attribute record parser.
`default_nettype none

package karp_pkg;

    // Default width of the parameter record counter
    localparam int KARP_COUNT_BITS = 16;

    // Record walk phases
    localparam logic [1:0] PH_FORMAT = 2'd0;
    localparam logic [1:0] PH_ATTR   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Attribute ids
    localparam logic [15:0] ID_REGISTERS  = 16'h001B;
    localparam logic [15:0] ID_SHARED_MEM = 16'h000F;
    localparam logic [15:0] ID_PARAM_BANK = 16'h0019;
    localparam logic [15:0] ID_PARAM_INFO = 16'h0017;
    localparam logic [15:0] ID_BARRIERS   = 16'h001F;

    // Format upper half that marks a sized record
    localparam logic [15:0] SIZED_FORMAT = 16'h0004;

    // Substitutes for absent or zero totals
    localparam logic [31:0] DEFAULT_REGISTERS = 32'd16;
    localparam logic [31:0] DEFAULT_BARRIERS  = 32'd1;

    // Totals after the current word has been applied
    typedef struct packed {
        logic [31:0] registers;
        logic [31:0] shared_mem;
        logic [31:0] param_bank;
        logic [15:0] param_count;
        logic [31:0] barriers;
    } karp_totals_t;

endpackage

`default_nettype wire

FILE: rtl/karp_walker.sv
// Record walker: phase tracking, padding skip and attribute accumulators.
`default_nettype none

module karp_walker
    import karp_pkg::*;
#(
    parameter int COUNT_BITS = KARP_COUNT_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         take,
    input  wire logic [31:0]  section_word,
    input  wire logic         final_word,
    output karp_totals_t      totals
);

    // Counter is as wide as the saturation limit needs, never above 16 bits
    localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [1:0]       phase_reg,  phase_next;
    logic [31:0]      format_reg, format_next;
    logic [15:0]      attr_reg,   attr_next;
    logic [29:0]      skip_reg,   skip_next;
    logic [31:0]      regs_reg,   regs_next;
    logic [31:0]      shmem_reg,  shmem_next;
    logic [31:0]      bank_reg,   bank_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [31:0]      bar_reg,    bar_next;

    // Record length: value rounded up to whole words, no wraparound
    logic [32:0] round_sum;
    logic [30:0] value_words;
    logic [29:0] pad_words;

    assign round_sum   = {1'b0, section_word} + 33'd3;
    assign value_words = round_sum[32:2];
    assign pad_words   = 30'(value_words - 31'd1);

    // Per-word state update
    always_comb begin
        phase_next  = phase_reg;
        format_next = format_reg;
        attr_next   = attr_reg;
        skip_next   = skip_reg;
        regs_next   = regs_reg;
        shmem_next  = shmem_reg;
        bank_next   = bank_reg;
        cnt_next    = cnt_reg;
        bar_next    = bar_reg;
        case (phase_reg)
            PH_FORMAT: begin
                format_next = section_word;
                phase_next  = PH_ATTR;
            end
            PH_ATTR: begin
                attr_next  = section_word[15:0];
                phase_next = PH_VALUE;
            end
            PH_VALUE: begin
                case (attr_reg)
                    ID_REGISTERS:  regs_next  = section_word;
                    ID_SHARED_MEM: shmem_next = section_word;
                    ID_PARAM_BANK: bank_next  = section_word;
                    ID_PARAM_INFO: begin
                        if (cnt_reg != CNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    ID_BARRIERS:   bar_next   = section_word;
                    default: ;
                endcase
                if (format_reg[31:16] != SIZED_FORMAT) begin
                    phase_next = PH_FORMAT;
                end else if (section_word == 32'd0) begin
                    // Zero length: value word doubles as the next format word
                    format_next = section_word;
                    phase_next  = PH_ATTR;
                end else if (pad_words == 30'd0) begin
                    phase_next = PH_FORMAT;
                end else begin
                    skip_next  = pad_words;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_reg <= 30'd1) begin
                    skip_next  = 30'd0;
                    phase_next = PH_FORMAT;
                end else begin
                    skip_next = skip_reg - 30'd1;
                end
            end
            default: phase_next = PH_FORMAT;
        endcase
    end

    // Totals including the current word
    always_comb begin
        totals.registers   = regs_next;
        totals.shared_mem  = shmem_next;
        totals.param_bank  = bank_next;
        totals.param_count = 16'(cnt_next);
        totals.barriers    = bar_next;
    end

    // State registers; the final word returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (take && final_word)) begin
            phase_reg  <= PH_FORMAT;
            format_reg <= '0;
            attr_reg   <= '0;
            skip_reg   <= '0;
            regs_reg   <= '0;
            shmem_reg  <= '0;
            bank_reg   <= '0;
            cnt_reg    <= '0;
            bar_reg    <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            format_reg <= format_next;
            attr_reg   <= attr_next;
            skip_reg   <= skip_next;
            regs_reg   <= regs_next;
            shmem_reg  <= shmem_next;
            bank_reg   <= bank_next;
            cnt_reg    <= cnt_next;
            bar_reg    <= bar_next;
        end
    end

    // Padding phase always has at least one word left
    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (skip_reg != 30'd0))
        else $error("skip phase with no padding left");

    // Final word clears the walk
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && final_word) |=> (phase_reg == PH_FORMAT && cnt_reg == '0
                                  && regs_reg == 32'd0))
        else $error("state not cleared after final word");

    // Counter never wraps back to zero
    a_cnt_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !final_word && cnt_reg != '0) |=> (cnt_reg != '0))
        else $error("parameter count wrapped");

endmodule

`default_nettype wire

FILE: rtl/kernel_attribute_record_parser_core.sv
// Timing: an accepted word is held in the input register until it advances into the walker;
// the totals for a final word are then registered into the result register and shown on m_.
// Throughput: one word per cycle, set by the record walker; a final word
// waits only while the previous result is still unread.
// Reset: synchronous active-low aresetn empties both registers and returns the walker
// to the format phase with all totals at zero.
`default_nettype none

module kernel_attribute_record_parser_core
    import karp_pkg::*;
#(
    parameter int COUNT_BITS = KARP_COUNT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_section_word,
    input  wire logic        s_final_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_register_count,
    output logic [31:0]      m_shared_mem_bytes,
    output logic [31:0]      m_param_bank_bytes,
    output logic [15:0]      m_param_count,
    output logic [31:0]      m_barrier_total
);

    logic         in_valid_reg;
    logic [31:0]  word_reg;
    logic         final_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         emit;
    karp_totals_t totals;

    // A final word advances only when the result register can take it
    assign advance = in_valid_reg && (!final_reg || !out_valid_reg || m_ready);
    assign emit    = advance && final_reg;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg  <= s_section_word;
            final_reg <= s_final_word;
        end
    end

    karp_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (advance),
        .section_word (word_reg),
        .final_word   (final_reg),
        .totals       (totals)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_register_count   <= (totals.registers == 32'd0) ? DEFAULT_REGISTERS
                                                              : totals.registers;
            m_shared_mem_bytes <= totals.shared_mem;
            m_param_bank_bytes <= totals.param_bank;
            m_param_count      <= totals.param_count;
            m_barrier_total    <= (totals.barriers == 32'd0) ? DEFAULT_BARRIERS
                                                             : totals.barriers;
        end
    end

    // A held word stays put until it advances
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(word_reg)
                                        && $stable(final_reg)))
        else $error("held word lost or changed");

    // Emitting a result always shows it next cycle
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("result not presented");

    // Never overwrite an unread result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !emit)
        else $error("result overwritten");

    // Back-pressure only comes from a stalled final word
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && final_reg && out_valid_reg && !m_ready))
        else $error("unexpected input stall");

endmodule

`default_nettype wire
